// ===== hdl/ebb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebb_pkg
// Shared types and constants for the error burst breaker with restart backoff.
// ----------------------------------------------------------------------------
package ebb_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_MS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_DELAY_MS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DELAY_MS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_RUN_MS = 3'd4;

   // register reset values
   localparam logic [COUNT_W-1:0] RST_BURST_THRESHOLD = 8'd20;
   localparam logic [TIME_W-1:0] RST_WINDOW_MS = 32'd60000;
   localparam logic [TIME_W-1:0] RST_FIRST_DELAY_MS = 32'd300000;
   localparam logic [TIME_W-1:0] RST_MAX_DELAY_MS = 32'd3600000;
   localparam logic [TIME_W-1:0] RST_STABLE_RUN_MS = 32'd1800000;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [COUNT_W-1:0] burst_threshold;
      logic [TIME_W-1:0]  window_ms;
      logic [TIME_W-1:0]  first_delay_ms;
      logic [TIME_W-1:0]  max_delay_ms;
      logic [TIME_W-1:0]  stable_run_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              error_seen;
      logic              link_up;
      logic              start_ok;
   } item_type;

   typedef struct packed {
      logic              agent_running;
      logic              send_now;
      logic              stopped_now;
      logic              restart_tried;
      logic [TIME_W-1:0] delay_now_ms;
   } result_type;

endpackage

// ===== hdl/ebb_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebb_req_if
// Poll channel: one beat carries the time and the three status flags.
// ----------------------------------------------------------------------------
interface ebb_req_if;
   import ebb_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_ms;
   logic              error_seen;
   logic              link_up;
   logic              start_ok;

   modport source (output valid, output now_ms, output error_seen, output link_up,
                   output start_ok, input ready);
   modport sink (input valid, input now_ms, input error_seen, input link_up,
                 input start_ok, output ready);
endinterface

// ===== hdl/ebb_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebb_rsp_if
// Result channel: one beat per poll with the agent status and current delay.
// ----------------------------------------------------------------------------
interface ebb_rsp_if;
   import ebb_pkg::*;

   logic              valid;
   logic              ready;
   logic              agent_running;
   logic              send_now;
   logic              stopped_now;
   logic              restart_tried;
   logic [TIME_W-1:0] delay_now_ms;

   modport source (output valid, output agent_running, output send_now,
                   output stopped_now, output restart_tried, output delay_now_ms,
                   input ready);
   modport sink (input valid, input agent_running, input send_now,
                 input stopped_now, input restart_tried, input delay_now_ms,
                 output ready);
endinterface

// ===== hdl/ebb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebb_core
// Breaker state and the single-pass poll step: window count, flood stop,
// stable-run delay reset and backoff restart.
// ----------------------------------------------------------------------------
module ebb_core (
   input  logic                clock,
   input  logic                reset,
   input  ebb_pkg::cfg_type    cfg,
   input  logic                step_en,
   input  ebb_pkg::item_type   item,
   output ebb_pkg::result_type res
);
   import ebb_pkg::*;

   logic               running_ff, running_in;
   logic               restart_armed_ff, restart_armed_in;
   logic               window_open_ff, window_open_in;
   logic [TIME_W-1:0]  window_begin_ff, window_begin_in;
   logic [COUNT_W-1:0] error_count_ff, error_count_in;
   logic               flood_ff, flood_in;
   logic [TIME_W-1:0]  stop_time_ff, stop_time_in;
   logic [TIME_W-1:0]  start_time_ff, start_time_in;
   logic [TIME_W-1:0]  delay_ff, delay_in;
   logic               send_armed_ff, send_armed_in;

   logic [TIME_W-1:0]  window_age;
   logic [TIME_W-1:0]  run_age;
   logic [TIME_W-1:0]  stop_age;
   logic [COUNT_W-1:0] count_inc;
   logic [TIME_W:0]    delay_dbl;
   logic               flood_mid;
   logic               send_now;
   logic               stopped_now;
   logic               tried;

   assign window_age = item.now_ms - window_begin_ff;
   assign run_age    = item.now_ms - start_time_ff;
   assign stop_age   = item.now_ms - stop_time_ff;
   assign count_inc  = (error_count_ff == COUNT_MAX) ? COUNT_MAX
                                                     : error_count_ff + COUNT_W'(1);
   assign delay_dbl  = {delay_ff, 1'b0};

   always_comb begin
      running_in       = running_ff;
      restart_armed_in = restart_armed_ff;
      window_open_in   = window_open_ff;
      window_begin_in  = window_begin_ff;
      error_count_in   = error_count_ff;
      stop_time_in     = stop_time_ff;
      start_time_in    = start_time_ff;
      delay_in         = delay_ff;
      send_armed_in    = send_armed_ff;
      flood_mid        = flood_ff;
      send_now         = 1'b0;
      stopped_now      = 1'b0;
      tried            = 1'b0;

      // count the error, opening a fresh window when needed
      if (item.error_seen) begin
         if (!window_open_ff || (window_age > cfg.window_ms)) begin
            window_open_in  = 1'b1;
            window_begin_in = item.now_ms;
            error_count_in  = COUNT_W'(1);
         end else begin
            error_count_in = count_inc;
            if (count_inc >= cfg.burst_threshold) begin
               flood_mid = 1'b1;
            end
         end
      end
      flood_in = flood_mid;

      if (running_ff) begin
         send_now      = send_armed_ff;
         send_armed_in = 1'b0;
         if (!flood_mid) begin
            if ((delay_ff != cfg.first_delay_ms) && (run_age > cfg.stable_run_ms)) begin
               delay_in = cfg.first_delay_ms;
            end
         end else begin
            flood_in         = 1'b0;
            running_in       = 1'b0;
            restart_armed_in = 1'b1;
            stop_time_in     = item.now_ms;
            stopped_now      = 1'b1;
         end
      end else if (restart_armed_ff && (stop_age >= delay_ff) && item.link_up) begin
         delay_in     = (delay_dbl > {1'b0, cfg.max_delay_ms}) ? cfg.max_delay_ms
                                                               : delay_dbl[TIME_W-1:0];
         stop_time_in = item.now_ms;
         tried        = 1'b1;
         if (item.start_ok) begin
            running_in      = 1'b1;
            start_time_in   = item.now_ms;
            window_open_in  = 1'b0;
            window_begin_in = '0;
            error_count_in  = '0;
            flood_in        = 1'b0;
            send_armed_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff       <= 1'b1;
         restart_armed_ff <= 1'b0;
         window_open_ff   <= 1'b0;
         window_begin_ff  <= '0;
         error_count_ff   <= '0;
         flood_ff         <= 1'b0;
         stop_time_ff     <= '0;
         start_time_ff    <= '0;
         delay_ff         <= RST_FIRST_DELAY_MS;
         send_armed_ff    <= 1'b1;
      end else if (step_en) begin
         running_ff       <= running_in;
         restart_armed_ff <= restart_armed_in;
         window_open_ff   <= window_open_in;
         window_begin_ff  <= window_begin_in;
         error_count_ff   <= error_count_in;
         flood_ff         <= flood_in;
         stop_time_ff     <= stop_time_in;
         start_time_ff    <= start_time_in;
         delay_ff         <= delay_in;
         send_armed_ff    <= send_armed_in;
      end
   end

   assign res.agent_running = running_in;
   assign res.send_now      = send_now;
   assign res.stopped_now   = stopped_now;
   assign res.restart_tried = tried;
   assign res.delay_now_ms  = delay_in;

`ifndef SYNTHESIS
   a_stop_xor_restart: assert property (@(posedge clock) disable iff (reset)
      step_en |-> !(stopped_now && tried))
      else $error("stop and restart in the same poll");

   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      step_en && stopped_now |=> !running_ff && restart_armed_ff)
      else $error("flood stop did not halt the agent");

   a_send_when_running: assert property (@(posedge clock) disable iff (reset)
      step_en && send_now |-> running_ff && !tried)
      else $error("send issued while agent stopped");

   a_open_window_counts: assert property (@(posedge clock) disable iff (reset)
      window_open_ff |-> error_count_ff != '0)
      else $error("open window with zero error count");
`endif

endmodule

// ===== hdl/error_burst_breaker_with_backoff.sv =====
`timescale 1ns / 1ps
// Path: an accepted poll beat is held in the input register, and its step result is
// captured in the result register, which drives the result channel.
// Throughput: one poll per cycle, sustained, while the result side keeps taking beats.
// The rate is set by the single-pass step between the input register and the result
// register; the breaker state updates once per poll.
// Reset (synchronous, active high): empties both registers, restores register defaults
// and puts the agent in the running state with one send armed.
// ----------------------------------------------------------------------------
// error_burst_breaker_with_backoff
// Counts transport errors in a time window, stops the agent on a flood and
// restarts it with an exponentially growing delay.
// ----------------------------------------------------------------------------
module error_burst_breaker_with_backoff (
   input  logic                                clock,
   input  logic                                reset,
   ebb_req_if.sink                             req_chan,
   ebb_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [ebb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ebb_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ebb_pkg::*;

   // configuration registers
   cfg_type    cfg_ff, cfg_in;

   // input register stage
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;

   // result register stage
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;

   result_type step_res;
   logic       req_fire;
   logic       advance;

   // Decode register writes; indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BURST_THRESHOLD: cfg_in.burst_threshold = csr_wdata[COUNT_W-1:0];
            CSR_WINDOW_MS:       cfg_in.window_ms       = csr_wdata[TIME_W-1:0];
            CSR_FIRST_DELAY_MS:  cfg_in.first_delay_ms  = csr_wdata[TIME_W-1:0];
            CSR_MAX_DELAY_MS:    cfg_in.max_delay_ms    = csr_wdata[TIME_W-1:0];
            CSR_STABLE_RUN_MS:   cfg_in.stable_run_ms   = csr_wdata[TIME_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.burst_threshold <= RST_BURST_THRESHOLD;
         cfg_ff.window_ms       <= RST_WINDOW_MS;
         cfg_ff.first_delay_ms  <= RST_FIRST_DELAY_MS;
         cfg_ff.max_delay_ms    <= RST_MAX_DELAY_MS;
         cfg_ff.stable_run_ms   <= RST_STABLE_RUN_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance the held poll into the result register whenever that register is
   // empty or its beat is being taken this cycle. The input register takes a
   // new beat whenever its current one moves on, so a waiting result never
   // blocks the poll behind it for more than the one held slot.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in           = 1'b1;
         in_item_in.now_ms     = req_chan.now_ms;
         in_item_in.error_seen = req_chan.error_seen;
         in_item_in.link_up    = req_chan.link_up;
         in_item_in.start_ok   = req_chan.start_ok;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Run the breaker step on the held poll; state commits only on advance.
   ebb_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step_en (advance),
      .item    (in_item_ff),
      .res     (step_res)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_res_in   = step_res;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.agent_running = out_res_ff.agent_running;
   assign rsp_chan.send_now      = out_res_ff.send_now;
   assign rsp_chan.stopped_now   = out_res_ff.stopped_now;
   assign rsp_chan.restart_tried = out_res_ff.restart_tried;
   assign rsp_chan.delay_now_ms  = out_res_ff.delay_now_ms;

endmodule
